@@ rtl/ssp_pkg.sv @@
// Shared constants and types for the sprite screen projection core.
`timescale 1ns / 1ps

package ssp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PLAYER_POS_X   = 3'd0,
    REG_PLAYER_POS_Y   = 3'd1,
    REG_VIEW_DIR_X     = 3'd2,
    REG_VIEW_DIR_Y     = 3'd3,
    REG_CAMERA_PLANE_X = 3'd4,
    REG_CAMERA_PLANE_Y = 3'd5,
    REG_SCREEN_WIDTH   = 3'd6,
    REG_SCREEN_HEIGHT  = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] RST_PLAYER_POS_X   = 16'd0;
  localparam logic [15:0] RST_PLAYER_POS_Y   = 16'd0;
  localparam logic [15:0] RST_VIEW_DIR_X     = 16'd16384;
  localparam logic [15:0] RST_VIEW_DIR_Y     = 16'd0;
  localparam logic [15:0] RST_CAMERA_PLANE_X = 16'd0;
  localparam logic [15:0] RST_CAMERA_PLANE_Y = 16'd10813;
  localparam logic [12:0] RST_SCREEN_WIDTH   = 13'd640;
  localparam logic [12:0] RST_SCREEN_HEIGHT  = 13'd480;

  localparam int VERTICAL_MOVE_DEF  = 0;
  localparam int HEIGHT_DIVISOR_DEF = 1;
  localparam int WIDTH_DIVISOR_DEF  = 1;

  // quotient bits of the two divider banks
  localparam int DEPTH_QW = 32;
  localparam int PROJ_QW  = 16;

endpackage

@@ rtl/sprite_screen_projection_core.sv @@
// Top level of the sprite screen projection core.
`timescale 1ns / 1ps

// Projects one sprite world position per word into screen space for a
// ray-casting renderer: the position relative to the player goes through the
// inverse camera matrix, giving a Q16.16 depth, the centre column, vertical
// shift, projected height and width, and the draw rectangle clamped to the
// screen. The core takes one word every clock while in_ready is high and,
// through 58 register stages, presents each result on the outputs in
// order; the latency is set by the two pipelined divider banks (32 stages
// for depth, then 16 stages for the centre, shift, height and width
// quotients) plus the multiply, saturate and clamp stages. A finished result
// waits in an output register backed by a one-word skid stage, so the
// pipeline keeps moving for one extra word after the consumer stalls; when
// the skid stage is full the whole pipeline holds.
// A sprite at or behind the camera, or a degenerate camera, gives status 1
// with every field but depth and frame_done forced to zero. Write the
// configuration only while the core is idle; writes are always taken.
module sprite_screen_projection_core #(
  parameter int VERTICAL_MOVE  = ssp_pkg::VERTICAL_MOVE_DEF,
  parameter int HEIGHT_DIVISOR = ssp_pkg::HEIGHT_DIVISOR_DEF,
  parameter int WIDTH_DIVISOR  = ssp_pkg::WIDTH_DIVISOR_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // sprite input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        sprite_pos_x,
  input  logic [15:0]        sprite_pos_y,
  input  logic               last_in_frame,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic signed [31:0] depth,
  output logic signed [15:0] center_column,
  output logic signed [15:0] vertical_shift,
  output logic [14:0]        sprite_height,
  output logic [14:0]        sprite_width,
  output logic [11:0]        top_row,
  output logic signed [15:0] bottom_row,
  output logic [14:0]        left_column,
  output logic signed [15:0] right_column,
  output logic               frame_done
);

  // divisors below one behave as one
  localparam int HDIV   = (HEIGHT_DIVISOR < 1) ? 1 : HEIGHT_DIVISOR;
  localparam int WDIV   = (WIDTH_DIVISOR < 1) ? 1 : WIDTH_DIVISOR;
  localparam int VM_MAG = (VERTICAL_MOVE < 0) ? -VERTICAL_MOVE : VERTICAL_MOVE;
  localparam logic VM_NEG = VERTICAL_MOVE < 0;
  localparam logic [31:0] SHIFT_NUM = 32'(VM_MAG * 65536);

  localparam int DQW = ssp_pkg::DEPTH_QW;
  localparam int PQW = ssp_pkg::PROJ_QW;

  typedef struct packed {
    logic        frame;
    logic        det_zero;
    logic        neg;
    logic        c_neg;
    logic [47:0] p_abs;
    logic [33:0] ny_abs;
  } side_a_t;

  typedef struct packed {
    logic               frame;
    logic               pos;
    logic signed [31:0] depth;
    logic               c_neg;
  } side_b_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] depth;
    logic signed [15:0] centre;
    logic signed [15:0] shift;
    logic [14:0]        sh;
    logic [14:0]        sw;
    logic [11:0]        top;
    logic signed [15:0] bottom;
    logic [14:0]        left;
    logic signed [15:0] right;
    logic               frame;
  } res_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0]        player_x;
  logic [15:0]        player_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] plane_x;
  logic signed [15:0] plane_y;
  logic [12:0]        scr_w;
  logic [12:0]        scr_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= ssp_pkg::RST_PLAYER_POS_X;
      player_y <= ssp_pkg::RST_PLAYER_POS_Y;
      dir_x    <= ssp_pkg::RST_VIEW_DIR_X;
      dir_y    <= ssp_pkg::RST_VIEW_DIR_Y;
      plane_x  <= ssp_pkg::RST_CAMERA_PLANE_X;
      plane_y  <= ssp_pkg::RST_CAMERA_PLANE_Y;
      scr_w    <= ssp_pkg::RST_SCREEN_WIDTH;
      scr_h    <= ssp_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_valid) begin
      unique case (ssp_pkg::cfg_reg_t'(cfg_index))
        ssp_pkg::REG_PLAYER_POS_X:   player_x <= cfg_data;
        ssp_pkg::REG_PLAYER_POS_Y:   player_y <= cfg_data;
        ssp_pkg::REG_VIEW_DIR_X:     dir_x    <= cfg_data;
        ssp_pkg::REG_VIEW_DIR_Y:     dir_y    <= cfg_data;
        ssp_pkg::REG_CAMERA_PLANE_X: plane_x  <= cfg_data;
        ssp_pkg::REG_CAMERA_PLANE_Y: plane_y  <= cfg_data;
        ssp_pkg::REG_SCREEN_WIDTH:   scr_w    <= cfg_data[12:0];
        ssp_pkg::REG_SCREEN_HEIGHT:  scr_h    <= cfg_data[12:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline advance: hold everything only while the skid stage is full
  // ---------------------------------------------------------------------
  logic en;
  logic skid_v;

  assign en       = ~skid_v;
  assign in_ready = en;

  // Stage 1: position relative to the player (17-bit signed)
  logic               v1;
  logic               s1_frame;
  logic signed [16:0] s1_rx;
  logic signed [16:0] s1_ry;

  // Stage 2: the six products of the inverse camera transform
  logic               v2;
  logic               s2_frame;
  logic signed [32:0] s2_a;
  logic signed [32:0] s2_b;
  logic signed [32:0] s2_c;
  logic signed [32:0] s2_d;
  logic signed [31:0] s2_e;
  logic signed [31:0] s2_f;

  // Stage 3: ny, ny + nx, and the determinant
  logic               v3;
  logic               s3_frame;
  logic signed [33:0] s3_ny;
  logic signed [34:0] s3_sum;
  logic signed [32:0] s3_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_frame <= last_in_frame;
      s1_rx    <= $signed({1'b0, sprite_pos_x} - {1'b0, player_x});
      s1_ry    <= $signed({1'b0, sprite_pos_y} - {1'b0, player_y});

      s2_frame <= s1_frame;
      s2_a     <= plane_x * s1_ry;
      s2_b     <= plane_y * s1_rx;
      s2_c     <= dir_y * s1_rx;
      s2_d     <= dir_x * s1_ry;
      s2_e     <= plane_x * dir_y;
      s2_f     <= dir_x * plane_y;

      s3_frame <= s2_frame;
      s3_ny    <= 34'(s2_a) - 34'(s2_b);
      s3_sum   <= 35'(s2_a) - 35'(s2_b) + 35'(s2_c) - 35'(s2_d);
      s3_det   <= 33'(s2_e) - 33'(s2_f);
    end
  end

  // ---------------------------------------------------------------------
  // Depth division: |ny| * 2^22 / |det|, centre numerator rides alongside
  // ---------------------------------------------------------------------
  logic [33:0]        ny_abs;
  logic [32:0]        det_abs;
  logic signed [47:0] p_full;
  logic [47:0]        p_abs;
  side_a_t            sa_in;
  side_a_t            sa_out;
  logic               va_out;
  logic [DQW-1:0]     dq;
  logic               dovf;

  assign ny_abs  = s3_ny[33] ? 34'(-s3_ny) : 34'(s3_ny);
  assign det_abs = s3_det[32] ? 33'(-s3_det) : 33'(s3_det);
  assign p_full  = $signed({1'b0, scr_w[12:1]}) * s3_sum;
  assign p_abs   = p_full[47] ? 48'(-p_full) : 48'(p_full);

  always_comb begin
    sa_in.frame    = s3_frame;
    sa_in.det_zero = s3_det == '0;
    sa_in.neg      = s3_ny[33] ^ s3_det[32];
    sa_in.c_neg    = p_full[47] ^ s3_ny[33];
    sa_in.p_abs    = p_abs;
    sa_in.ny_abs   = ny_abs;
  end

  ssp_div #(.NW(56), .DW(33), .QW(DQW)) u_depth_div (
    .clk (clk),
    .en  (en),
    .num ({ny_abs, 22'b0}),
    .den (det_abs),
    .quo (dq),
    .ovf (dovf)
  );

  ssp_delay #(.W($bits(side_a_t)), .N(DQW + 1)) u_side_a (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v3),
    .din  (sa_in),
    .vout (va_out),
    .dout (sa_out)
  );

  // Stage D: saturate depth to 32 bits, decide front/behind
  logic signed [31:0] depth_sat;
  logic               depth_pos;
  logic               vd;
  logic               d_frame;
  logic               d_pos;
  logic signed [31:0] d_depth;
  logic               d_cneg;
  logic [47:0]        d_pabs;
  logic [33:0]        d_nyabs;

  always_comb begin
    if (sa_out.det_zero) begin
      depth_sat = '0;
    end else if (!sa_out.neg) begin
      depth_sat = (dovf || dq[31]) ? 32'sh7FFF_FFFF : $signed(dq);
    end else begin
      depth_sat = (dovf || dq > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-dq);
    end
    depth_pos = !sa_out.det_zero && !sa_out.neg && (dovf || dq != '0);
  end

  // Stage E: divisors and numerators for the projection bank
  logic               ve;
  side_b_t            sb_in;
  logic [47:0]        e_cn;
  logic [33:0]        e_cd;
  logic [31:0]        e_sd;
  logic [35:0]        e_hd;
  logic [35:0]        e_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (en) begin
      vd <= va_out;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_frame <= sa_out.frame;
      d_pos   <= depth_pos;
      d_depth <= depth_sat;
      d_cneg  <= sa_out.c_neg;
      d_pabs  <= sa_out.p_abs;
      d_nyabs <= sa_out.ny_abs;

      sb_in.frame <= d_frame;
      sb_in.pos   <= d_pos;
      sb_in.depth <= d_depth;
      sb_in.c_neg <= d_cneg;
      e_cn        <= d_pabs;
      e_cd        <= d_nyabs;
      e_sd        <= $unsigned(d_depth);
      e_hd        <= 36'($unsigned(d_depth)) * 36'(HDIV);
      e_wd        <= 36'($unsigned(d_depth)) * 36'(WDIV);
    end
  end

  // ---------------------------------------------------------------------
  // Projection bank: centre, shift, height and width quotients in parallel
  // ---------------------------------------------------------------------
  logic [PQW-1:0] cq, shq, hq, wq;
  logic           covf, shovf, hovf, wovf;
  side_b_t        sb_out;
  logic           vb_out;

  ssp_div #(.NW(48), .DW(34), .QW(PQW)) u_centre_div (
    .clk (clk), .en (en), .num (e_cn), .den (e_cd), .quo (cq), .ovf (covf)
  );

  ssp_div #(.NW(32), .DW(32), .QW(PQW)) u_shift_div (
    .clk (clk), .en (en), .num (SHIFT_NUM), .den (e_sd), .quo (shq), .ovf (shovf)
  );

  ssp_div #(.NW(29), .DW(36), .QW(PQW)) u_height_div (
    .clk (clk), .en (en), .num ({scr_h, 16'b0}), .den (e_hd), .quo (hq), .ovf (hovf)
  );

  ssp_div #(.NW(29), .DW(36), .QW(PQW)) u_width_div (
    .clk (clk), .en (en), .num ({scr_h, 16'b0}), .den (e_wd), .quo (wq), .ovf (wovf)
  );

  ssp_delay #(.W($bits(side_b_t)), .N(PQW + 1)) u_side_b (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (ve),
    .din  (sb_in),
    .vout (vb_out),
    .dout (sb_out)
  );

  // Stage F: saturate the four quotients
  logic               vf;
  logic               f_frame;
  logic               f_pos;
  logic signed [31:0] f_depth;
  logic signed [15:0] f_centre;
  logic signed [15:0] f_shift;
  logic [14:0]        f_sh;
  logic [14:0]        f_sw;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vb_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_frame <= sb_out.frame;
      f_pos   <= sb_out.pos;
      f_depth <= sb_out.depth;
      if (!sb_out.c_neg) begin
        f_centre <= (covf || cq[15]) ? 16'sh7FFF : $signed(cq);
      end else begin
        f_centre <= (covf || cq > 16'h8000) ? 16'sh8000 : $signed(-cq);
      end
      if (!VM_NEG) begin
        f_shift <= (shovf || shq[15]) ? 16'sh7FFF : $signed(shq);
      end else begin
        f_shift <= (shovf || shq > 16'h8000) ? 16'sh8000 : $signed(-shq);
      end
      f_sh <= (hovf || hq[15]) ? 15'h7FFF : hq[14:0];
      f_sw <= (wovf || wq[15]) ? 15'h7FFF : wq[14:0];
    end
  end

  // Stage G: draw rectangle, clamp to the screen, blank hidden sprites
  logic signed [18:0] half_h;
  logic signed [18:0] top_raw;
  logic signed [18:0] bot_raw;
  logic signed [18:0] h_lim;
  logic signed [18:0] left_raw;
  logic signed [18:0] right_raw;
  logic signed [18:0] w_lim;
  res_t               g_res;
  res_t               g_next;
  logic               vg;

  always_comb begin
    half_h    = $signed({7'b0, scr_h[12:1]});
    top_raw   = 19'(f_shift) + half_h - $signed({5'b0, f_sh[14:1]});
    bot_raw   = 19'(f_shift) + half_h + $signed({5'b0, f_sh[14:1]});
    h_lim     = $signed({6'b0, scr_h}) - 19'sd1;
    left_raw  = 19'(f_centre) - $signed({5'b0, f_sw[14:1]});
    right_raw = 19'(f_centre) + $signed({5'b0, f_sw[14:1]});
    w_lim     = $signed({6'b0, scr_w}) - 19'sd1;

    g_next = '0;
    g_next.frame  = f_frame;
    g_next.depth  = f_depth;
    g_next.status = ~f_pos;
    if (f_pos) begin
      g_next.centre = f_centre;
      g_next.shift  = f_shift;
      g_next.sh     = f_sh;
      g_next.sw     = f_sw;
      if (top_raw < 0) begin
        g_next.top = '0;
      end else if (top_raw > 19'sd4095) begin
        g_next.top = 12'hFFF;
      end else begin
        g_next.top = top_raw[11:0];
      end
      g_next.bottom = (bot_raw > h_lim) ? h_lim[15:0] : bot_raw[15:0];
      g_next.left   = (left_raw < 0) ? '0 : left_raw[14:0];
      g_next.right  = (right_raw > w_lim) ? w_lim[15:0] : right_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_res <= g_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register and skid stage
  // ---------------------------------------------------------------------
  res_t out_res;
  res_t skid_res;
  logic push;
  logic take;

  assign push = en & vg;
  assign take = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      // drain the skid word first
      if (take) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_res <= g_res;
      end else begin
        skid_res <= g_res;
      end
    end
  end

  assign status         = out_res.status;
  assign depth          = out_res.depth;
  assign center_column  = out_res.centre;
  assign vertical_shift = out_res.shift;
  assign sprite_height  = out_res.sh;
  assign sprite_width   = out_res.sw;
  assign top_row        = out_res.top;
  assign bottom_row     = out_res.bottom;
  assign left_column    = out_res.left;
  assign right_column   = out_res.right;
  assign frame_done     = out_res.frame;

endmodule

@@ rtl/ssp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps

module ssp_div #(
  parameter int NW = 56,
  parameter int DW = 33,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int HW = NW - QW;
  localparam int CW = HW + DW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;
  logic          ovf_in;

  logic [DW-1:0] rem  [QW];
  logic [QW-1:0] lo   [QW];
  logic [DW-1:0] dv   [QW];
  logic [QW-1:0] quot [QW+1];
  logic          ov   [QW+1];

  // quotient would not fit in QW bits (also catches a zero divisor)
  assign hi_ext  = CW'(num[NW-1:QW]);
  assign den_ext = CW'(den);
  assign ovf_in  = hi_ext >= den_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= ovf_in ? '0 : hi_ext[DW-1:0];
      lo[0]   <= num[QW-1:0];
      dv[0]   <= den;
      quot[0] <= '0;
      ov[0]   <= ovf_in;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] part;
    logic [DW:0] diff;
    logic        ge;

    assign part = {rem[k], lo[k][QW-1]};
    assign ge   = part >= {1'b0, dv[k]};
    assign diff = part - {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        quot[k+1] <= {quot[k][QW-2:0], ge};
        ov[k+1]   <= ov[k];
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? diff[DW-1:0] : part[DW-1:0];
          lo[k+1]  <= lo[k] << 1;
          dv[k+1]  <= dv[k];
        end
      end
    end
  end

  assign quo = quot[QW];
  assign ovf = ov[QW];

endmodule

@@ rtl/ssp_delay.sv @@
// Delay line with valid bits, matched to the divider latency.
`timescale 1ns / 1ps

module ssp_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [N];
  logic [N-1:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-2:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int k = 1; k < N; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign vout = v[N-1];
  assign dout = line[N-1];

endmodule
